/* src/pft_pkg.sv */
// Shared types, constants and tables for the planar frame transform.
package pft_pkg;

	localparam int ANGLE_STAGES_DEF = 16;
	localparam int ANGLE_STAGES_MAX = 32;

	// heading is degrees Q9.8, one full turn is 360 degrees
	localparam int HALF_TURN_DEG = 180;
	localparam int FULL_TURN_Q = 2 * HALF_TURN_DEG * 256;

	// 92160 = 45 * 2^11, so the binary-angle conversion only divides by 45
	localparam int TURN_SHIFT = 11;
	localparam int ANG_DIV = FULL_TURN_Q / (1 << TURN_SHIFT);
	localparam int FRAC_BIAS = (FULL_TURN_Q / 2) / (1 << TURN_SHIFT);
	localparam int QUO_BITS = 11;
	localparam int FRAC_BITS = 32 - QUO_BITS;
	localparam int RECIP_BITS = 23;
	localparam int ANG_RECIP = (1 << RECIP_BITS) / ANG_DIV + 1;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	localparam logic MODE_TO_MAP = 1'b0;
	localparam logic MODE_TO_ROBOT = 1'b1;

	typedef enum logic [1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_HEADING  = 2'd2
	} pft_reg_t;

	typedef struct packed {
		logic              mode;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} pft_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
	} pft_out_t;

	// point operands after the origin step, kept at 33 bits
	typedef struct packed {
		logic              mode;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} pft_opnd_t;

	// rotation state handed from stage to stage
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic              neg;
	} pft_rot_t;

	// atan(2^-i) in binary angle units, full turn = 2^32
	localparam logic [31:0] ATAN_TAB [ANGLE_STAGES_MAX] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81,
		32'd41, 32'd20, 32'd10, 32'd5,
		32'd3, 32'd1, 32'd1, 32'd0
	};

	// fractional part of the binary angle for each remainder mod 45
	typedef logic [FRAC_BITS-1:0] frac_lut_t [64];

	function automatic frac_lut_t frac_lut_build();
		frac_lut_t tab;
		for (int i = 0; i < 64; i++) begin
			if (i < ANG_DIV) begin
				tab[i] = FRAC_BITS'((i * (1 << FRAC_BITS) + FRAC_BIAS) / ANG_DIV);
			end else begin
				tab[i] = '0;
			end
		end
		return tab;
	endfunction

	localparam frac_lut_t FRAC_LUT = frac_lut_build();

endpackage

/* src/planar_frame_transform.sv */
// Top level: configuration registers, operand setup and the CORDIC cell chain.
//
// Moves a Q16.16 point between the robot frame and the map frame using the
// pose held in three registers (origin x, origin y, heading in degrees Q9.8).
// Configuration: cfg_we/cfg_idx/cfg_data write one register per cycle, taken
// at once; an unknown index is dropped. Write only while no word is in flight.
// Input: a word in cmd is taken on a clock edge with start high and busy low.
// busy is high only during reset and the first cycle after it; from then on
// one word is taken every cycle.
// Output: done is high for one cycle with the word on result. Results leave
// in the order of acceptance. The receiver cannot hold results off, and
// none is needed: the pipeline never stalls.
// Timing is set by the chain: 4 angle-prep stages, one stage per CORDIC cell,
// then 5 stages of cos/sin fix, multiply, sum, round and the output register.
// Reset clears the pose to zero and empties the pipeline.
module planar_frame_transform import pft_pkg::*; #(
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pft_in_t     cmd,
	output logic        done,
	output pft_out_t    result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	// edges from the accepting edge to the edge that takes the result
	localparam int LAT = ANGLE_STAGES + 9;

	logic signed [31:0] origin_x_q, origin_y_q;
	logic signed [17:0] heading_q;
	logic              busy_q;

	logic              acc_c;
	pft_opnd_t         opnd_c;

	logic              rot_vld [ANGLE_STAGES+1];
	pft_rot_t          rot_d [ANGLE_STAGES+1];
	pft_opnd_t         rot_opnd [ANGLE_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			heading_q <= '0;
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				case (pft_reg_t'(cfg_idx))
					REG_ORIGIN_X: origin_x_q <= cfg_data;
					REG_ORIGIN_Y: origin_y_q <= cfg_data;
					REG_HEADING:  heading_q <= cfg_data[17:0];
					default: ;
				endcase
			end
		end
	end

	assign busy = busy_q;
	assign acc_c = start & ~busy_q;

	// map to robot takes the origin off before rotating
	always_comb begin
		opnd_c.mode = cmd.mode;
		opnd_c.a = {cmd.point_x[31], cmd.point_x};
		opnd_c.b = {cmd.point_y[31], cmd.point_y};
		if (cmd.mode == MODE_TO_ROBOT) begin
			opnd_c.a = opnd_c.a - {origin_x_q[31], origin_x_q};
			opnd_c.b = opnd_c.b - {origin_y_q[31], origin_y_q};
		end
	end

	pft_angle_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (acc_c),
		.heading   (heading_q),
		.opnd      (opnd_c),
		.fold_vld  (rot_vld[0]),
		.fold      (rot_d[0]),
		.fold_opnd (rot_opnd[0])
	);

	for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
		pft_cordic_cell #(.STAGE(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (rot_vld[k]),
			.rot      (rot_d[k]),
			.opnd     (rot_opnd[k]),
			.nxt_vld  (rot_vld[k+1]),
			.nxt_rot  (rot_d[k+1]),
			.nxt_opnd (rot_opnd[k+1])
		);
	end

	pft_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (rot_vld[ANGLE_STAGES]),
		.rot      (rot_d[ANGLE_STAGES]),
		.opnd     (rot_opnd[ANGLE_STAGES]),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.done     (done),
		.result   (result)
	);

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without an accepted word");

	a_word_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted word produced no result");

endmodule

/* src/pft_angle_prep.sv */
// Heading to folded binary angle: wrap, divide by 45, table lookup, quadrant fold.
module pft_angle_prep import pft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  logic signed [17:0] heading,
	input  pft_opnd_t         opnd,
	output logic              fold_vld,
	output pft_rot_t          fold,
	output pft_opnd_t         fold_opnd
);

	localparam logic signed [18:0] TURN1 = 19'(FULL_TURN_Q);
	localparam logic signed [18:0] TURN2 = 19'(2 * FULL_TURN_Q);

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	pft_opnd_t         opnd_s1, opnd_s2, opnd_s3, opnd_s4;
	logic [16:0]       r_s1, r_s2;
	logic [QUO_BITS-1:0] q_s2, q_s3;
	logic [5:0]        m_s3;
	pft_rot_t          rot_s4;

	logic signed [18:0] hx_c, hr_c;
	logic [34:0]       prod_c;
	logic [16:0]       qm_c, rem_c;
	logic [31:0]       t_c;
	logic              neg_c;

	// wrap heading into one turn
	always_comb begin
		hx_c = {heading[17], heading};
		if (hx_c < -TURN1) begin
			hr_c = hx_c + TURN2;
		end else if (hx_c < 19'sd0) begin
			hr_c = hx_c + TURN1;
		end else if (hx_c >= TURN1) begin
			hr_c = hx_c - TURN1;
		end else begin
			hr_c = hx_c;
		end
	end

	// r / 45 by reciprocal, exact for r below one turn
	assign prod_c = r_s1 * 18'(ANG_RECIP);
	assign qm_c = 17'(q_s2) * 17'(ANG_DIV);
	assign rem_c = r_s2 - qm_c;

	always_comb begin
		t_c = {q_s3, FRAC_BITS'(0)} + {QUO_BITS'(0), FRAC_LUT[m_s3]};
		// outside [-90, 90] degrees: move half a turn, negate the result later
		neg_c = t_c[31] ? ~t_c[30] : (t_c[30] & (|t_c[29:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		opnd_s1 <= opnd;
		r_s1 <= hr_c[16:0];
		opnd_s2 <= opnd_s1;
		r_s2 <= r_s1;
		q_s2 <= prod_c[RECIP_BITS +: QUO_BITS];
		opnd_s3 <= opnd_s2;
		q_s3 <= q_s2;
		m_s3 <= rem_c[5:0];
		opnd_s4 <= opnd_s3;
		rot_s4.x <= CORDIC_GAIN;
		rot_s4.y <= 32'sd0;
		rot_s4.z <= neg_c ? {~t_c[31], t_c[30:0]} : t_c;
		rot_s4.neg <= neg_c;
	end

	assign fold_vld = vld_s4;
	assign fold = rot_s4;
	assign fold_opnd = opnd_s4;

	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (r_s1 < 17'(FULL_TURN_Q)))
		else $error("wrapped heading out of range");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (m_s3 < 6'(ANG_DIV)))
		else $error("reciprocal divide left a remainder of 45 or more");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		fold_vld |-> (fold.z <= ONE_Q30 && fold.z >= -ONE_Q30))
		else $error("folded angle outside a quarter turn");

endmodule

/* src/pft_cordic_cell.sv */
// One CORDIC rotation stage with its pipeline register.
module pft_cordic_cell import pft_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld,
	input  pft_rot_t  rot,
	input  pft_opnd_t opnd,
	output logic      nxt_vld,
	output pft_rot_t  nxt_rot,
	output pft_opnd_t nxt_opnd
);

	logic      vld_s1;
	pft_rot_t  rot_s1;
	pft_opnd_t opnd_s1;

	logic signed [31:0] dx_c, dy_c;
	pft_rot_t  rot_c;

	always_comb begin
		dx_c = rot.y >>> STAGE;
		dy_c = rot.x >>> STAGE;
		rot_c = rot;
		if (!rot.z[31]) begin
			rot_c.x = rot.x - dx_c;
			rot_c.y = rot.y + dy_c;
			rot_c.z = rot.z - ATAN_TAB[STAGE];
		end else begin
			rot_c.x = rot.x + dx_c;
			rot_c.y = rot.y - dy_c;
			rot_c.z = rot.z + ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		rot_s1 <= rot_c;
		opnd_s1 <= opnd;
	end

	assign nxt_vld = vld_s1;
	assign nxt_rot = rot_s1;
	assign nxt_opnd = opnd_s1;

endmodule

/* src/pft_rotate.sv */
// Sign fix and clamp of cos/sin, point rotation, rounding, origin add, saturation.
module pft_rotate import pft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  pft_rot_t          rot,
	input  pft_opnd_t         opnd,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	output logic              done,
	output pft_out_t          result
);

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic              mode_s1, mode_s2, mode_s3, mode_s4;
	logic signed [32:0] a_s1, b_s1;
	logic signed [31:0] c_s1, s_s1;
	logic signed [63:0] p_ca_s2, p_sb_s2, p_sa_s2, p_cb_s2;
	logic signed [63:0] sx_s3, sy_s3;
	logic signed [34:0] rx_s4, ry_s4;
	pft_out_t          result_s5;

	logic signed [31:0] xn_c, yn_c, c_c, s_c;
	logic signed [63:0] p_ca_c, p_sb_c, p_sa_c, p_cb_c;
	logic signed [63:0] ha_c, hb_c, hs_c, hc_c;
	logic              cb_c, cs_c;
	logic signed [63:0] rx_c, ry_c;
	logic signed [35:0] vx_c, vy_c;

	function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
		if (v > ONE_Q30) begin
			return ONE_Q30;
		end else if (v < -ONE_Q30) begin
			return -ONE_Q30;
		end
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
			return v[31:0];
		end
		return v[35] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
	endfunction

	always_comb begin
		xn_c = rot.neg ? -rot.x : rot.x;
		yn_c = rot.neg ? -rot.y : rot.y;
		c_c = clamp_q30(xn_c);
		s_c = clamp_q30(yn_c);
	end

	assign p_ca_c = c_s1 * a_s1;
	assign p_sb_c = s_s1 * b_s1;
	assign p_sa_c = s_s1 * a_s1;
	assign p_cb_c = c_s1 * b_s1;

	// floor(-p/2) = ~(p >>> 1) + !p[0]
	always_comb begin
		ha_c = p_ca_s2 >>> 1;
		hc_c = p_cb_s2 >>> 1;
		hb_c = (mode_s2 == MODE_TO_ROBOT) ? ~(p_sb_s2 >>> 1) : (p_sb_s2 >>> 1);
		hs_c = (mode_s2 == MODE_TO_ROBOT) ? (p_sa_s2 >>> 1) : ~(p_sa_s2 >>> 1);
		cb_c = (mode_s2 == MODE_TO_ROBOT) & ~p_sb_s2[0];
		cs_c = (mode_s2 == MODE_TO_MAP) & ~p_sa_s2[0];
		rx_c = ha_c + hb_c + 64'(cb_c);
		ry_c = hs_c + hc_c + 64'(cs_c);
	end

	always_comb begin
		vx_c = {rx_s4[34], rx_s4};
		vy_c = {ry_s4[34], ry_s4};
		if (mode_s4 == MODE_TO_MAP) begin
			vx_c = vx_c + {{4{origin_x[31]}}, origin_x};
			vy_c = vy_c + {{4{origin_y[31]}}, origin_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= opnd.mode;
		a_s1 <= opnd.a;
		b_s1 <= opnd.b;
		c_s1 <= c_c;
		s_s1 <= s_c;
		mode_s2 <= mode_s1;
		p_ca_s2 <= p_ca_c;
		p_sb_s2 <= p_sb_c;
		p_sa_s2 <= p_sa_c;
		p_cb_s2 <= p_cb_c;
		mode_s3 <= mode_s2;
		sx_s3 <= rx_c;
		sy_s3 <= ry_c;
		mode_s4 <= mode_s3;
		// round half up from Q*.45 to Q16.16
		rx_s4 <= 35'((sx_s3 + 64'sd268435456) >>> 29);
		ry_s4 <= 35'((sy_s3 + 64'sd268435456) >>> 29);
		result_s5.out_x <= sat32(vx_c);
		result_s5.out_y <= sat32(vy_c);
	end

	assign done = vld_s5;
	assign result = result_s5;

endmodule

/* verif/planar_frame_transform_tb.sv */
// Self-checking testbench for the planar frame transform: streams points under several poses.
`timescale 1ns / 100ps

module planar_frame_transform_tb;
	import pft_pkg::*;

	localparam int STAGES = ANGLE_STAGES_DEF;
	localparam int ROT_STAGES = (STAGES > 32) ? 32 : STAGES;
	localparam int FLUSH_CYCLES = 2 * (STAGES + 8);
	localparam int RANDOM_PHASES = 10;
	localparam int WORDS_PER_PHASE = 150;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam longint Q30_ONE = 64'sd1 <<< 30;
	localparam longint GAIN = 64'sd652032874;

	// atan(2^-i), full turn = 2^32
	localparam longint ATAN_STEP [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	// quadrant edges and full-turn wraps, degrees Q9.8
	localparam int HEAD_MARKS [12] = '{
		0, 23040, 23039, 23041, 46080, -23040, -46080, 69120, 92160, -92160,
		92161, -92161
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	pft_in_t     cmd = '0;
	logic        done;
	pft_out_t    result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	pft_in_t  pending_pts[$];
	pft_out_t expected_pts[$];
	longint   pose_ox = 0;
	longint   pose_oy = 0;
	longint   pose_hd = 0;
	int       fails = 0;
	int       gap_left = 0;
	int       burst_left = 1;

	planar_frame_transform #(.ANGLE_STAGES(STAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Q2.30 x Q16.16 products, halved, summed, rounded half up to Q16.16
	function automatic longint rot_sum(longint k1, longint d1, longint k2, longint d2);
		longint h;
		h = ((k1 * d1) >>> 1) + ((k2 * d2) >>> 1);
		return (h + (64'sd1 <<< 28)) >>> 29;
	endfunction

	function automatic pft_out_t transform_point(pft_in_t w);
		longint turn, ang, bx, by, step_x, step_y, c, s;
		longint px, py, ax, ay, rx, ry;
		logic flip;
		pft_out_t o;
		turn = pose_hd % FULL_TURN_Q;
		if (turn < 0) begin
			turn += FULL_TURN_Q;
		end
		ang = ((turn <<< 32) + FULL_TURN_Q / 2) / FULL_TURN_Q;
		ang = ang % (64'sd1 <<< 32);
		if (ang >= (64'sd1 <<< 31)) begin
			ang -= (64'sd1 <<< 32);
		end
		// fold the back half-plane by a half turn, negate at the end
		flip = (ang > Q30_ONE) || (ang < -Q30_ONE);
		if (flip) begin
			ang += (ang > 0) ? -(64'sd1 <<< 31) : (64'sd1 <<< 31);
		end
		bx = GAIN;
		by = 0;
		for (int i = 0; i < ROT_STAGES; i++) begin
			step_x = by >>> i;
			step_y = bx >>> i;
			if (ang >= 0) begin
				bx -= step_x;
				by += step_y;
				ang -= ATAN_STEP[i];
			end else begin
				bx += step_x;
				by -= step_y;
				ang += ATAN_STEP[i];
			end
		end
		if (flip) begin
			bx = -bx;
			by = -by;
		end
		c = clamp_to(bx, -Q30_ONE, Q30_ONE);
		s = clamp_to(by, -Q30_ONE, Q30_ONE);
		px = longint'(w.point_x);
		py = longint'(w.point_y);
		if (w.mode == MODE_TO_MAP) begin
			rx = rot_sum(c, px, s, py) + pose_ox;
			ry = rot_sum(-s, px, c, py) + pose_oy;
		end else begin
			// difference stays at 33 bits before the rotation
			ax = px - pose_ox;
			ay = py - pose_oy;
			rx = rot_sum(c, ax, -s, ay);
			ry = rot_sum(s, ax, c, ay);
		end
		o.out_x = 32'(clamp_to(rx, longint'(Q_MIN), longint'(Q_MAX)));
		o.out_y = 32'(clamp_to(ry, longint'(Q_MIN), longint'(Q_MAX)));
		return o;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			default: return $signed($urandom()) >>> $urandom_range(0, 24);
		endcase
	endfunction

	function automatic logic [17:0] rand_heading();
		case ($urandom_range(0, 3))
			0: return 18'(HEAD_MARKS[$urandom_range(0, 11)]);
			1: return 18'(($urandom_range(0, 22) - 11) * 11520 + $urandom_range(0, 2) - 1);
			default: return 18'($urandom());
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X: pose_ox = longint'(signed'(data));
			REG_ORIGIN_Y: pose_oy = longint'(signed'(data));
			REG_HEADING:  pose_hd = longint'(signed'(data[17:0]));
			default: ;
		endcase
	endtask

	// upper bits of the heading word are don't-care
	task automatic write_heading(input logic [17:0] hd);
		logic [31:0] data;
		data = $urandom();
		data[17:0] = hd;
		write_reg(REG_HEADING, data);
	endtask

	task automatic queue_point(input logic mode, input logic signed [31:0] x,
			input logic signed [31:0] y);
		pft_in_t w;
		w.mode = mode;
		w.point_x = x;
		w.point_y = y;
		pending_pts.push_back(w);
	endtask

	// wait until every word is taken and answered, then let the pipe flush
	task automatic settle();
		while (pending_pts.size() != 0 || start || expected_pts.size() != 0) begin
			@(negedge clk);
		end
		repeat (FLUSH_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (start && !busy) begin
			expected_pts.push_back(transform_point(cmd));
		end
		if (!(start && busy)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_pts.size() != 0) begin
				start <= 1'b1;
				cmd <= pending_pts.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pft_out_t want;
		if (arst_n && done) begin
			if (expected_pts.size() == 0) begin
				$error("unexpected result word: out_x %0d out_y %0d",
					result.out_x, result.out_y);
				fails++;
			end else begin
				want = expected_pts.pop_front();
				if (result.out_x !== want.out_x) begin
					$error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
					fails++;
				end
				if (result.out_y !== want.out_y) begin
					$error("out_y: expected %0d, got %0d", want.out_y, result.out_y);
					fails++;
				end
			end
		end
	end

	initial begin
		int ph, n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset pose
		@(negedge clk);
		queue_point(MODE_TO_MAP, '0, '0);
		queue_point(MODE_TO_ROBOT, '0, '0);
		queue_point(MODE_TO_MAP, Q_MAX, Q_MAX);
		queue_point(MODE_TO_MAP, Q_MIN, Q_MIN);
		queue_point(MODE_TO_ROBOT, Q_MAX, Q_MIN);
		queue_point(MODE_TO_ROBOT, Q_MIN, Q_MAX);
		queue_point(MODE_TO_MAP, 32'sd1, -32'sd1);
		queue_point(MODE_TO_MAP, 32'sh0001_0000, '0);
		settle();

		// full turn wraps to zero; origin extremes force saturation and a 33-bit difference
		write_reg(REG_ORIGIN_X, Q_MAX);
		write_reg(REG_ORIGIN_Y, Q_MIN);
		write_heading(18'(FULL_TURN_Q));
		@(negedge clk);
		queue_point(MODE_TO_MAP, Q_MAX, Q_MIN);
		queue_point(MODE_TO_MAP, Q_MIN, Q_MAX);
		queue_point(MODE_TO_ROBOT, Q_MIN, Q_MAX);
		queue_point(MODE_TO_ROBOT, Q_MAX, Q_MIN);
		settle();

		// quarter turn; a write to the spare index must not touch the pose
		write_reg(REG_ORIGIN_X, Q_MIN);
		write_reg(REG_ORIGIN_Y, Q_MAX);
		write_heading(18'd23040);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		@(negedge clk);
		queue_point(MODE_TO_MAP, Q_MAX, Q_MAX);
		queue_point(MODE_TO_ROBOT, Q_MAX, Q_MIN);
		queue_point(MODE_TO_MAP, 32'sh1234_5678, -32'sh1234_5678);
		settle();

		// heading register extremes, beyond a full turn both ways
		write_reg(REG_ORIGIN_X, 32'sh0003_8000);
		write_reg(REG_ORIGIN_Y, -32'sh0001_4000);
		write_heading(18'h20000);
		@(negedge clk);
		queue_point(MODE_TO_MAP, 32'sh0010_0000, 32'sh0020_0000);
		queue_point(MODE_TO_ROBOT, -32'sh0010_0000, 32'sh0004_0000);
		queue_point(MODE_TO_ROBOT, Q_MIN, Q_MIN);
		settle();
		write_heading(18'h1FFFF);
		@(negedge clk);
		queue_point(MODE_TO_MAP, 32'sh0010_0000, -32'sh0020_0000);
		queue_point(MODE_TO_ROBOT, 32'sh7FFF_0000, 32'sh0000_FFFF);
		queue_point(MODE_TO_MAP, Q_MAX, Q_MIN);
		settle();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(REG_ORIGIN_X, rand_coord());
			write_reg(REG_ORIGIN_Y, rand_coord());
			write_heading(rand_heading());
			write_reg(REG_SPARE, $urandom());
			@(negedge clk);
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				queue_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord());
			end
			settle();
		end

		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
